### hdl/wsp_pkg.sv
// wsp_pkg: types and constants for the wav stream parser
// used by every module under hdl
`default_nettype none
package wsp_pkg;
  typedef enum logic [3:0] {
    PH_HEADER, PH_CHUNKHDR, PH_FMT, PH_SKIP, PH_PAD,
    PH_DATA, PH_OK, PH_NOTRIFF, PH_BEFORE, PH_UNSUP
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NOTRIFF = 3'd1, ST_BEFORE = 3'd2, ST_UNSUP = 3'd3, ST_NODATA = 3'd4
  } status_t;

  // result sequencer of the top level
  typedef enum logic [1:0] {S_IDLE, S_DIV, S_STATUS} seq_t;

  localparam logic [31:0] TAG_RIFF = 32'h46464952;
  localparam logic [31:0] TAG_WAVE = 32'h45564157;
  localparam logic [31:0] TAG_FMT  = 32'h20746D66;
  localparam logic [31:0] TAG_DATA = 32'h61746164;

  localparam int SUM_W = 40;
  localparam int DIV_W = 16;
endpackage
`default_nettype wire

### hdl/wsp_div.sv
// wsp_div: restoring divider, one quotient bit per cycle, signed dividend
// depends on wsp_pkg
`default_nettype none
module wsp_div import wsp_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [SUM_W-1:0] dividend,
  input  wire logic        [DIV_W-1:0] divisor,
  output logic                         busy,
  output logic                         done,
  output logic signed [15:0]           quotient
);
  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_W:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0] den_r;
  logic             neg_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [DIV_W:0]   trial;
  logic [SUM_W-1:0] mag, qfin;

  assign mag = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
  assign trial = {rem_r[DIV_W-1:0], quo_r[SUM_W-1]};

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = mag;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift-subtract step
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= divisor;
      neg_r <= dividend[SUM_W-1];
    end
  end

  assign qfin = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign quotient = qfin[15:0];
  assign busy = busy_r;
  assign done = done_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without busy");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("busy with zero count");
  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while busy");
endmodule
`default_nettype wire

### hdl/wav_stream_parser_downmix.sv
// wav_stream_parser_downmix: byte-serial RIFF/WAVE PCM16 parser with mono downmix
// depends on wsp_pkg and wsp_div
//
// Input channel: in_valid/in_stall with in_data_byte and in_end_of_file, one file
// byte per item. Result channel: out_valid/out_stall with sample and status fields.
// A byte that produces no result is taken and the block is ready again on the
// next cycle. A byte that completes a frame of two or more channels starts the
// serial divider: 40 quotient bits, one per cycle, after which the sample is
// presented. The end_of_file byte yields a status item (after the sample, if it
// also completes a frame). Each result is held in an output register until
// taken; while a result waits there no new byte is accepted. Reset (rst_n low,
// synchronous) returns the parser to the file header state and drops any
// pending result. After a status item the parser starts over for a new file.
`default_nettype none
module wav_stream_parser_downmix import wsp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_file,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_result_kind,
  output logic signed [15:0] out_mono_sample,
  output logic [2:0]       out_status_code,
  output logic [31:0]      out_rate_hz,
  output logic [15:0]      out_channel_count,
  output logic             out_last
);
  phase_t ph_r, ph_nxt;
  seq_t   sq_r, sq_nxt;
  logic [31:0] cnt_r, cnt_nxt, len_r, len_nxt, tag_r, tag_nxt, rate_r, rate_nxt;
  logic [15:0] fmtc_r, fmtc_nxt, nch_r, nch_nxt, bits_r, bits_nxt, chi_r, chi_nxt;
  logic        seen_r, seen_nxt, eofp_r, eofp_nxt;
  logic [7:0]  low_r, low_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [2:0]  code_r, code_nxt;
  logic signed [15:0] samp_r, samp_nxt;
  logic        ov_r, ov_nxt, okind_r, okind_nxt;
  logic        div_start, div_busy, div_done;
  logic signed [15:0] div_q;
  logic        acc;
  logic        go_div, emit;
  logic [31:0] cnt1;
  logic signed [15:0] s;
  logic signed [SUM_W-1:0] sum_add;
  logic [15:0] chi1;

  assign in_stall = (sq_r != S_IDLE) || ov_r;
  assign acc = in_valid && !in_stall;
  assign cnt1 = cnt_r + 32'd1;
  assign s = {in_data_byte, low_r};
  assign sum_add = sum_r + SUM_W'(s);
  assign chi1 = chi_r + 16'd1;

  function automatic logic [2:0] code_of(phase_t p);
    unique case (p)
      PH_HEADER, PH_NOTRIFF: code_of = ST_NOTRIFF;
      PH_DATA, PH_OK:        code_of = ST_OK;
      PH_BEFORE:             code_of = ST_BEFORE;
      PH_UNSUP:              code_of = ST_UNSUP;
      default:               code_of = ST_NODATA;
    endcase
  endfunction

  always_comb begin
    ph_nxt = ph_r; sq_nxt = sq_r; cnt_nxt = cnt_r; len_nxt = len_r; tag_nxt = tag_r;
    rate_nxt = rate_r; fmtc_nxt = fmtc_r; nch_nxt = nch_r; bits_nxt = bits_r;
    chi_nxt = chi_r; seen_nxt = seen_r; eofp_nxt = eofp_r; low_nxt = low_r;
    sum_nxt = sum_r; code_nxt = code_r; samp_nxt = samp_r; ov_nxt = ov_r;
    okind_nxt = okind_r; div_start = 1'b0;
    go_div = 1'b0; emit = 1'b0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (sq_r)
      S_IDLE: begin
        if (acc) begin
          unique case (ph_r)
            PH_HEADER: begin
              tag_nxt = {in_data_byte, tag_r[31:8]};
              cnt_nxt = cnt1;
              if (cnt1 == 32'd4 && tag_nxt != TAG_RIFF) ph_nxt = PH_NOTRIFF;
              else if (cnt1 == 32'd12) begin
                ph_nxt = (tag_nxt == TAG_WAVE) ? PH_CHUNKHDR : PH_NOTRIFF;
                cnt_nxt = '0;
              end
            end
            PH_CHUNKHDR: begin
              if (cnt_r < 32'd4) tag_nxt = {in_data_byte, tag_r[31:8]};
              else len_nxt = {in_data_byte, len_r[31:8]};
              cnt_nxt = cnt1;
              if (cnt1 == 32'd8) begin
                cnt_nxt = '0;
                if (tag_r == TAG_FMT) begin
                  ph_nxt = (len_nxt == '0) ? PH_CHUNKHDR : PH_FMT;
                end else if (tag_r == TAG_DATA) begin
                  if (!seen_r) ph_nxt = PH_BEFORE;
                  else if (fmtc_r != 16'd1 || bits_r != 16'd16) ph_nxt = PH_UNSUP;
                  else ph_nxt = (len_nxt == '0) ? PH_OK : PH_DATA;
                  chi_nxt = '0;
                  sum_nxt = '0;
                end else if (len_nxt == '0) ph_nxt = PH_CHUNKHDR;
                else ph_nxt = PH_SKIP;
              end
            end
            PH_FMT: begin
              if (len_r >= 32'd16 && cnt_r < 32'd16) begin
                unique case (cnt_r[3:0])
                  4'd0:  fmtc_nxt = {8'd0, in_data_byte};
                  4'd1:  fmtc_nxt = {in_data_byte, fmtc_r[7:0]};
                  4'd2:  nch_nxt = {8'd0, in_data_byte};
                  4'd3:  nch_nxt = {in_data_byte, nch_r[7:0]};
                  4'd4:  rate_nxt = {24'd0, in_data_byte};
                  4'd5:  rate_nxt = {rate_r[31:16], in_data_byte, rate_r[7:0]};
                  4'd6:  rate_nxt = {rate_r[31:24], in_data_byte, rate_r[15:0]};
                  4'd7:  rate_nxt = {in_data_byte, rate_r[23:0]};
                  4'd14: bits_nxt = {8'd0, in_data_byte};
                  4'd15: begin
                    bits_nxt = {in_data_byte, bits_r[7:0]};
                    seen_nxt = 1'b1;
                  end
                  default: ;
                endcase
              end
              cnt_nxt = cnt1;
              if (cnt1 == len_r) begin ph_nxt = PH_CHUNKHDR; cnt_nxt = '0; end
            end
            PH_SKIP: begin
              cnt_nxt = cnt1;
              if (cnt1 == len_r) begin
                cnt_nxt = '0;
                ph_nxt = len_r[0] ? PH_PAD : PH_CHUNKHDR;
              end
            end
            PH_PAD: begin ph_nxt = PH_CHUNKHDR; cnt_nxt = '0; end
            PH_DATA: begin
              if (!cnt_r[0]) low_nxt = in_data_byte;
              else if (nch_r <= 16'd1) begin
                samp_nxt = s; emit = 1'b1;
              end else begin
                sum_nxt = sum_add;
                chi_nxt = chi1;
                if (chi1 == nch_r) begin
                  go_div = 1'b1;
                  sum_nxt = '0;
                  chi_nxt = '0;
                end
              end
              cnt_nxt = cnt1;
              if (cnt1 == len_r) ph_nxt = PH_OK;
            end
            default: ;
          endcase
          code_nxt = code_of(ph_nxt);
          eofp_nxt = in_end_of_file;
          if (go_div) begin
            div_start = 1'b1;
            sq_nxt = S_DIV;
          end else if (emit) begin
            ov_nxt = 1'b1; okind_nxt = 1'b0;
            sq_nxt = in_end_of_file ? S_STATUS : S_IDLE;
          end else if (in_end_of_file) begin
            ov_nxt = 1'b1; okind_nxt = 1'b1;
          end
        end else if (ov_r && !out_stall && okind_r) begin
          // status taken: start over for next file
          ph_nxt = PH_HEADER; cnt_nxt = '0; len_nxt = '0; tag_nxt = '0;
          rate_nxt = '0; fmtc_nxt = '0; nch_nxt = '0; bits_nxt = '0;
          seen_nxt = 1'b0; low_nxt = '0; chi_nxt = '0; sum_nxt = '0;
        end
      end
      S_DIV: begin
        if (div_done) begin
          samp_nxt = div_q;
          ov_nxt = 1'b1; okind_nxt = 1'b0;
          sq_nxt = eofp_r ? S_STATUS : S_IDLE;
        end
      end
      S_STATUS: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1; okind_nxt = 1'b1; sq_nxt = S_IDLE;
        end
      end
      default: sq_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_HEADER; sq_r <= S_IDLE; cnt_r <= '0; len_r <= '0; tag_r <= '0;
      rate_r <= '0; fmtc_r <= '0; nch_r <= '0; bits_r <= '0; chi_r <= '0;
      seen_r <= 1'b0; eofp_r <= 1'b0; low_r <= '0; sum_r <= '0; ov_r <= 1'b0;
      okind_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt; sq_r <= sq_nxt; cnt_r <= cnt_nxt; len_r <= len_nxt;
      tag_r <= tag_nxt; rate_r <= rate_nxt; fmtc_r <= fmtc_nxt; nch_r <= nch_nxt;
      bits_r <= bits_nxt; chi_r <= chi_nxt; seen_r <= seen_nxt; eofp_r <= eofp_nxt;
      low_r <= low_nxt; sum_r <= sum_nxt; ov_r <= ov_nxt; okind_r <= okind_nxt;
    end
    code_r <= code_nxt;
    samp_r <= samp_nxt;
  end

  wsp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_add),
    .divisor(nch_r), .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  assign out_valid = ov_r;
  assign out_result_kind = okind_r;
  assign out_mono_sample = okind_r ? 16'sd0 : samp_r;
  assign out_status_code = okind_r ? code_r : 3'd0;
  assign out_rate_hz = rate_r;
  assign out_channel_count = nch_r;
  assign out_last = okind_r;

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_r == S_DIV) |-> (div_busy || div_done)) else $error("divider idle in div state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_r != S_IDLE) |-> !acc) else $error("byte taken while busy");
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && okind_r) |-> (code_r <= 3'd4)) else $error("bad status code");
endmodule
`default_nettype wire

### tb/wav_stream_parser_downmix_check.sv
// result checker for wav_stream_parser_downmix: watches both channels,
// predicts each result from the accepted bytes and compares; depends on wsp_pkg
module wav_stream_parser_downmix_check import wsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              in_end_of_file,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_result_kind,
  input  logic signed [15:0] out_mono_sample,
  input  logic [2:0]        out_status_code,
  input  logic [31:0]       out_rate_hz,
  input  logic [15:0]       out_channel_count,
  input  logic              out_last,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        kind;
    logic [15:0] sample;
    logic [2:0]  code;
    logic [31:0] rate;
    logic [15:0] chans;
    logic        last;
  } wav_result_t;

  wav_result_t expected_results[$];

  phase_t      ph;
  logic [31:0] nbytes, clen, tag;
  logic [15:0] fmt_code, nch, bits;
  logic [31:0] rate;
  logic        fmt_valid;
  logic [7:0]  lo;
  logic [15:0] ch_idx;
  longint      acc;

  function automatic wav_result_t make_result(logic kind, logic [15:0] smp,
                                              logic [2:0] code);
    wav_result_t r;
    r.kind = kind; r.sample = smp; r.code = code;
    r.rate = rate; r.chans = nch; r.last = kind;
    return r;
  endfunction

  task automatic clear_parser();
    ph = PH_HEADER; nbytes = 0; clen = 0; tag = 0; fmt_code = 0; nch = 0;
    rate = 0; bits = 0; fmt_valid = 0; lo = 0; ch_idx = 0; acc = 0;
  endtask

  task automatic parse_byte(logic [7:0] b, logic eof);
    logic [15:0] raw;
    longint      s, avg;
    status_t     st;
    case (ph)
      PH_HEADER: begin
        tag = {b, tag[31:8]};
        nbytes++;
        if (nbytes == 4 && tag != TAG_RIFF) ph = PH_NOTRIFF;
        else if (nbytes == 12) begin
          ph = (tag == TAG_WAVE) ? PH_CHUNKHDR : PH_NOTRIFF;
          nbytes = 0;
        end
      end
      PH_CHUNKHDR: begin
        if (nbytes < 4) tag = {b, tag[31:8]};
        else clen = {b, clen[31:8]};
        nbytes++;
        if (nbytes == 8) begin
          nbytes = 0;
          if (tag == TAG_FMT) ph = (clen == 0) ? PH_CHUNKHDR : PH_FMT;
          else if (tag == TAG_DATA) begin
            if (!fmt_valid) ph = PH_BEFORE;
            else if (fmt_code != 1 || bits != 16) ph = PH_UNSUP;
            else ph = (clen == 0) ? PH_OK : PH_DATA;
            ch_idx = 0; acc = 0;
          end else ph = (clen == 0) ? PH_CHUNKHDR : PH_SKIP;
        end
      end
      PH_FMT: begin
        if (clen >= 16 && nbytes < 16) begin
          case (nbytes)
            0: fmt_code[7:0] = b;  1: fmt_code[15:8] = b;
            2: nch[7:0] = b;       3: nch[15:8] = b;
            4: rate[7:0] = b;      5: rate[15:8] = b;
            6: rate[23:16] = b;    7: rate[31:24] = b;
            14: bits[7:0] = b;
            15: begin bits[15:8] = b; fmt_valid = 1; end
            default: ;
          endcase
          // first byte of each field clears the upper part
          if (nbytes == 0) fmt_code[15:8] = 0;
          if (nbytes == 2) nch[15:8] = 0;
          if (nbytes == 4) rate[31:8] = 0;
          if (nbytes == 14) bits[15:8] = 0;
        end
        nbytes++;
        if (nbytes == clen) begin ph = PH_CHUNKHDR; nbytes = 0; end
      end
      PH_SKIP: begin
        nbytes++;
        if (nbytes == clen) begin
          nbytes = 0;
          ph = clen[0] ? PH_PAD : PH_CHUNKHDR;
        end
      end
      PH_PAD: begin ph = PH_CHUNKHDR; nbytes = 0; end
      PH_DATA: begin
        if (!nbytes[0]) lo = b;
        else begin
          raw = {b, lo};
          s = longint'($signed(raw));
          if (nch <= 1) expected_results.push_back(make_result(1'b0, raw, ST_OK));
          else begin
            acc += s;
            ch_idx++;
            if (ch_idx == nch) begin
              avg = acc / longint'(nch);
              expected_results.push_back(make_result(1'b0, avg[15:0], ST_OK));
              acc = 0; ch_idx = 0;
            end
          end
        end
        nbytes++;
        if (nbytes == clen) ph = PH_OK;
      end
      default: ;
    endcase
    if (eof) begin
      case (ph)
        PH_HEADER, PH_NOTRIFF: st = ST_NOTRIFF;
        PH_DATA, PH_OK:        st = ST_OK;
        PH_BEFORE:             st = ST_BEFORE;
        PH_UNSUP:              st = ST_UNSUP;
        default:               st = ST_NODATA;
      endcase
      expected_results.push_back(make_result(1'b1, 16'd0, st));
      clear_parser();
    end
  endtask

  initial begin
    clear_parser();
    fail_count = 0;
  end

  always @(posedge clk) begin
    wav_result_t got, want;
    if (rst_n) begin
      if (in_valid && !in_stall) parse_byte(in_data_byte, in_end_of_file);
      if (out_valid && !out_stall) begin
        got = {out_result_kind, out_mono_sample, out_status_code, out_rate_hz,
               out_channel_count, out_last};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch exp: kind %0d sample %0d code %0d rate %0d ch %0d last %0d",
                want.kind, $signed(want.sample), want.code, want.rate, want.chans,
                want.last);
              $display("         got: kind %0d sample %0d code %0d rate %0d ch %0d last %0d",
                got.kind, $signed(got.sample), got.code, got.rate, got.chans, got.last);
            end
          end
        end
      end
    end
    pending <= expected_results.size();
  end
endmodule

### tb/wav_stream_parser_downmix_test.sv
// testbench top for wav_stream_parser_downmix: builds WAV byte streams,
// drives them with bursty valid and random stall; depends on the checker and wsp_pkg
module wav_stream_parser_downmix_test import wsp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, in_end_of_file = 0, out_stall = 0;
  logic [7:0] in_data_byte = 0;
  logic out_valid, out_result_kind, out_last;
  logic signed [15:0] out_mono_sample;
  logic [2:0] out_status_code;
  logic [31:0] out_rate_hz;
  logic [15:0] out_channel_count;
  int fail_count, pending, idle_cycles, sent;
  logic [8:0] file_bytes[$];  // {eof, byte}

  always #5 clk = ~clk;

  wav_stream_parser_downmix dut (.*);
  wav_stream_parser_downmix_check checker_i (.*);

  // receiver stall pattern: calm and busy stretches
  always @(posedge clk) begin
    int mode;
    mode = ($urandom_range(0, 199) == 0) ? $urandom_range(0, 2) : -1;
    if (mode == 0) out_stall <= 0;
    else out_stall <= (sent % 400 < 150) ? 1'b0 : ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("wav_stream_parser_downmix regression: fail");
      $finish;
    end
  end

  task automatic put32(logic [31:0] v);
    for (int i = 0; i < 4; i++) file_bytes.push_back({1'b0, v[8*i +: 8]});
  endtask

  task automatic put_fmt(logic [15:0] fmtc, logic [15:0] ch, logic [31:0] rt,
                         logic [15:0] bt, int extra);
    put32(TAG_FMT); put32(16 + extra);
    file_bytes.push_back({1'b0, fmtc[7:0]}); file_bytes.push_back({1'b0, fmtc[15:8]});
    file_bytes.push_back({1'b0, ch[7:0]});   file_bytes.push_back({1'b0, ch[15:8]});
    put32(rt); put32($urandom); file_bytes.push_back(9'd0); file_bytes.push_back(9'd0);
    file_bytes.push_back({1'b0, bt[7:0]});   file_bytes.push_back({1'b0, bt[15:8]});
    for (int i = 0; i < extra; i++) file_bytes.push_back({1'b0, 8'($urandom)});
  endtask

  // well-formed file with random content and optional damage
  task automatic build_file(int sel);
    int ch, len, nch;
    logic [15:0] v;
    put32(sel == 1 ? {$urandom} : TAG_RIFF); put32($urandom);
    put32(sel == 2 ? 32'h45564158 : TAG_WAVE);
    if ($urandom_range(0, 3) == 0) begin
      len = $urandom_range(0, 5);
      put32($urandom_range(0, 1) ? 32'h5453494c : TAG_FMT); put32(len);
      for (int i = 0; i < len + (len % 2); i++) file_bytes.push_back({1'b0, 8'($urandom)});
    end
    nch = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 6);
    if (sel == 8) nch = 16'hffff;
    if (sel != 3)
      put_fmt(sel == 4 ? 16'd3 : 16'd1, 16'(nch), $urandom, sel == 4 ? 16'd32 : 16'd16,
              $urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    if (sel == 5) begin
      file_bytes[$][8] = 1;
      return;
    end
    put32(TAG_DATA);
    ch = (nch < 2) ? 1 : nch;
    len = 2 * ch * $urandom_range(0, 5) + $urandom_range(0, 2) * $urandom_range(0, 1);
    if (sel == 8) len = 6;
    put32(len);
    for (int i = 0; i < len; i += 2) begin
      case ($urandom_range(0, 5))
        0: v = 16'h8000;
        1: v = 16'h7fff;
        2: v = 16'hffff;
        default: v = 16'($urandom);
      endcase
      file_bytes.push_back({1'b0, v[7:0]}); file_bytes.push_back({1'b0, v[15:8]});
    end
    if (len % 2) void'(file_bytes.pop_back());
    // trailing bytes, sometimes cut short
    if (sel == 6) for (int i = 0; i < 3; i++) void'(file_bytes.pop_back());
    for (int i = $urandom_range(0, 2); i > 0; i--) file_bytes.push_back({1'b0, 8'($urandom)});
    file_bytes[$][8] = 1;
  endtask

  // valid stays up between calls; the caller drops it after the last item
  task automatic send_all();
    int burst, gap;
    logic [8:0] bv;
    burst = 0;
    while (file_bytes.size() > 0) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 40);
      end
      bv = file_bytes[0];
      file_bytes.delete(0);
      in_valid <= 1; in_data_byte <= bv[7:0]; in_end_of_file <= bv[8];
      @(posedge clk);
      while (in_stall) @(posedge clk);
      sent++;
      burst--;
    end
  endtask

  initial begin
    sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: short file, single byte, each damage kind
    file_bytes.push_back({1'b1, 8'h52});
    for (int i = 0; i < 5; i++) file_bytes.push_back({1'b0, 8'h52});
    file_bytes[$][8] = 1;
    for (int s = 1; s <= 8; s++) build_file(s);
    send_all();
    while (sent < 1400) begin
      if ($urandom_range(0, 9) == 0) begin
        for (int i = $urandom_range(1, 30); i > 0; i--)
          file_bytes.push_back({1'b0, 8'($urandom)});
        file_bytes[$][8] = 1;
      end else build_file($urandom_range(0, 4) == 0 ? $urandom_range(1, 8) : 0);
      send_all();
    end
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("wav_stream_parser_downmix regression: pass");
    else $display("wav_stream_parser_downmix regression: fail");
    $finish;
  end
endmodule
